FILE: sv/cfpu_pkg.sv
// shared types, constants and beat formatting for the frequency plan unit
package cfpu_pkg;

    localparam logic [29:0] CEIL_HZ      = 30'd900000000;
    localparam logic [19:0] FRAC_DEN     = 20'd1048575;
    localparam logic [11:0] DIV_MAX      = 12'd2048;
    localparam logic [11:0] DIV_MIN      = 12'd4;
    localparam logic [17:0] P1_OFFSET    = 18'd512;
    localparam logic [25:0] CRYSTAL_RST  = 26'd25000000;

    localparam logic [7:0] REG_PLL_A    = 8'd26;
    localparam logic [7:0] REG_PLL_B    = 8'd34;
    localparam logic [7:0] REG_MS0      = 8'd42;
    localparam logic [7:0] REG_CLK0     = 8'd16;
    localparam logic [7:0] REG_PLL_RST  = 8'd177;
    localparam logic [7:0] CLK_ON       = 8'h4F;
    localparam logic [7:0] CLK_OFF      = 8'h80;
    localparam logic [7:0] SRC_PLL_B    = 8'h20;
    localparam logic [7:0] RST_PLL_A    = 8'h20;
    localparam logic [7:0] RST_PLL_B    = 8'h80;

    localparam logic [1:0] CHAN_NONE    = 2'd3;
    localparam logic [2:0] ADDR_CRYSTAL = 3'd0;

    // pipeline stage map
    localparam int ST_SAT      = 1;
    localparam int ST_D1_LAST  = 13;
    localparam int ST_VCO      = 14;
    localparam int ST_D2_LAST  = 61;
    localparam int ST_FRAC     = 62;
    localparam int ST_D3_LAST  = 82;
    localparam int ST_PACK     = 83;
    localparam int NSTAGE      = 84;

    localparam logic [4:0] BEAT_PLL_RST = 5'd16;
    localparam logic [4:0] BEAT_CLK     = 5'd17;

    typedef struct packed {
        logic [1:0]  chan;
        logic        pll_b;
        logic [2:0]  expo;
        logic        off;
        logic        sat;
        logic [34:0] scaled;
        logic [11:0] div;
        logic [46:0] acc;
        logic [25:0] rem;
        logic [19:0] q;
        logic [7:0]  mult;
        logic [17:0] p1_pll;
        logic [19:0] p2;
    } item_t;

    typedef struct packed {
        logic [1:0]  chan;
        logic        pll_b;
        logic [2:0]  expo;
        logic        off;
        logic [11:0] div;
        logic [17:0] p1_pll;
        logic [19:0] p2;
    } plan_t;

    typedef struct packed {
        logic       busy;
        logic [4:0] cnt;
    } emit_stat_t;

    function automatic logic [15:0] beat_word(plan_t p, logic [4:0] cnt);
        logic [18:0] ms_full;
        logic [17:0] ms_p1;
        logic [7:0]  addr;
        logic [7:0]  data;
        ms_full = {p.div, 7'b0} - 19'(P1_OFFSET);
        ms_p1   = ms_full[17:0];
        addr    = '0;
        data    = '0;
        if (p.off)
        begin
            addr = REG_CLK0 + 8'(p.chan);
            data = CLK_OFF;
        end
        else if (cnt < 5'd8)
        begin
            addr = (p.pll_b ? REG_PLL_B : REG_PLL_A) + 8'(cnt);
            case (cnt[2:0])
                3'd0: data = FRAC_DEN[15:8];
                3'd1: data = FRAC_DEN[7:0];
                3'd2: data = {6'b0, p.p1_pll[17:16]};
                3'd3: data = p.p1_pll[15:8];
                3'd4: data = p.p1_pll[7:0];
                3'd5: data = {4'hF, p.p2[19:16]};
                3'd6: data = p.p2[15:8];
                default: data = p.p2[7:0];
            endcase
        end
        else if (cnt < BEAT_PLL_RST)
        begin
            addr = REG_MS0 + {3'b0, p.chan, 3'b0} + 8'(cnt[2:0]);
            case (cnt[2:0])
                3'd0: data = 8'd0;
                3'd1: data = 8'd1;
                3'd2: data = {1'b0, p.expo, 2'b0, ms_p1[17:16]};
                3'd3: data = ms_p1[15:8];
                3'd4: data = ms_p1[7:0];
                default: data = 8'd0;
            endcase
        end
        else if (cnt == BEAT_PLL_RST)
        begin
            addr = REG_PLL_RST;
            data = p.pll_b ? RST_PLL_B : RST_PLL_A;
        end
        else
        begin
            addr = REG_CLK0 + 8'(p.chan);
            data = CLK_ON | (p.pll_b ? SRC_PLL_B : 8'h00);
        end
        return {addr, data};
    endfunction

endpackage

FILE: sv/cfpu_if.sv
// request and register write channel interfaces
interface cfpu_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  channel;
    logic [27:0] target_hz;
    logic        pll_select;
    logic [2:0]  rdiv_exponent;

    modport source (output valid, channel, target_hz, pll_select, rdiv_exponent, input ready);
    modport sink (input valid, channel, target_hz, pll_select, rdiv_exponent, output ready);
endinterface

interface cfpu_wr_if;
    logic       valid;
    logic       ready;
    logic [7:0] reg_addr;
    logic [7:0] reg_byte;
    logic       last;

    modport source (output valid, reg_addr, reg_byte, last, input ready);
    modport sink (input valid, reg_addr, reg_byte, last, output ready);
endinterface

FILE: sv/clock_synth_frequency_plan_unit.sv
// Frequency planner: one request per cycle, while the write sequencer does not stall the
// chain, enters an 84-stage pipeline of bit-per-stage restoring dividers (output divider,
// vco over crystal, 20-bit fraction); the first write beat is offered once the plan has
// left the last stage and been taken into the sequencer. A normal request then emits
// 18 beats, a power-down request one, an invalid channel none; the sequencer takes the
// next plan only as the final beat of the current one is accepted. No clearing pass after reset.
module clock_synth_frequency_plan_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    cfpu_req_if.sink    req,
    cfpu_wr_if.source   wr
);
    import cfpu_pkg::*;

    logic [25:0] crystal_reg;
    logic        pipe_en;
    logic        fin_valid;
    plan_t       fin_plan;
    logic        take_ready;
    emit_stat_t  stat;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crystal_reg <= CRYSTAL_RST;
        else if (psel && penable && pwrite && paddr[2] == ADDR_CRYSTAL[2])
            crystal_reg <= pwdata[25:0];
    end

    assign prdata = (paddr[2] == ADDR_CRYSTAL[2]) ? {6'b0, crystal_reg} : 32'd0;

    // the whole chain advances unless a finished plan waits on the sequencer
    assign pipe_en   = !fin_valid || take_ready;
    assign req.ready = pipe_en;

    cfpu_pipe u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (pipe_en),
        .in_valid     (req.valid),
        .channel      (req.channel),
        .target_hz    (req.target_hz),
        .pll_select   (req.pll_select),
        .rdiv_exponent(req.rdiv_exponent),
        .crystal      (crystal_reg),
        .fin_valid    (fin_valid),
        .fin_plan     (fin_plan)
    );

    cfpu_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .fin_valid (fin_valid),
        .fin_plan  (fin_plan),
        .take_ready(take_ready),
        .stat      (stat),
        .wr        (wr)
    );

`ifndef ASSERT_OFF
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (fin_valid && stat.busy))
        else $error("request side stalled without a busy sequencer");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        stat.busy |-> (stat.cnt <= BEAT_CLK))
        else $error("beat counter past the final write");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.valid && wr.ready && wr.last && !fin_valid) |=> !wr.valid)
        else $error("write beats continue after the final beat");

    a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
        (wr.valid && wr.ready && !wr.last) |=> (stat.cnt == $past(stat.cnt) + 5'd1))
        else $error("beat counter skipped or repeated a write");
`endif
endmodule

FILE: sv/cfpu_stage.sv
// one register stage of the divider pipeline
module cfpu_stage #(
    parameter int IDX = 1
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  cfpu_pkg::item_t in_item,
    input  logic [25:0]     crystal,
    output logic            out_valid,
    output cfpu_pkg::item_t out_item
);
    import cfpu_pkg::*;

    localparam int K1R = ST_D1_LAST - IDX;
    localparam int K1  = (K1R < 0) ? 0 : ((K1R > 11) ? 11 : K1R);
    localparam int BR  = ST_D2_LAST - IDX;
    localparam int B2  = (BR < 0) ? 0 : ((BR > 46) ? 46 : BR);
    localparam int K3R = ST_D3_LAST - IDX;
    localparam int K3  = (K3R < 0) ? 0 : ((K3R > 19) ? 19 : K3R);

    logic   valid_reg;
    item_t  item_reg;
    item_t  item_next;

    always_comb
    begin
        logic [46:0] t;
        logic [11:0] d;
        logic [26:0] r;
        logic        qb;
        logic [19:0] numv;
        logic [7:0]  multv;
        logic [26:0] x;
        logic [7:0]  q0;
        logic [20:0] r21;
        item_next = in_item;
        t     = '0;
        d     = '0;
        r     = '0;
        qb    = 1'b0;
        numv  = '0;
        multv = '0;
        x     = '0;
        q0    = '0;
        r21   = '0;
        if (IDX == ST_SAT)
        begin
            item_next.sat = {17'b0, CEIL_HZ} >= {in_item.scaled, 12'b0};
            item_next.acc = 47'(CEIL_HZ);
            item_next.q   = '0;
        end
        else if (IDX <= ST_D1_LAST)
        begin
            t = 47'(in_item.scaled) << K1;
            if (!in_item.sat && in_item.acc >= t)
            begin
                item_next.acc   = in_item.acc - t;
                item_next.q[K1] = 1'b1;
            end
        end
        else if (IDX == ST_VCO)
        begin
            if (in_item.sat || in_item.q[11:0] > DIV_MAX)
                d = DIV_MAX;
            else if (in_item.q[11:0] < DIV_MIN)
                d = DIV_MIN;
            else
                d = in_item.q[11:0];
            d[0] = 1'b0;
            item_next.div = d;
            item_next.acc = 47'(d) * 47'(in_item.scaled);
            item_next.rem = '0;
            item_next.q   = '0;
        end
        else if (IDX <= ST_D2_LAST)
        begin
            r = {in_item.rem, in_item.acc[B2]};
            if (r >= {1'b0, crystal})
            begin
                r  = r - {1'b0, crystal};
                qb = 1'b1;
            end
            item_next.rem = r[25:0];
            item_next.q   = {in_item.q[18:0], qb};
        end
        else if (IDX == ST_FRAC)
        begin
            item_next.mult = in_item.q[7:0];
            item_next.acc  = {1'b0, in_item.rem, 20'b0} - 47'(in_item.rem);
            item_next.q    = '0;
        end
        else if (IDX <= ST_D3_LAST)
        begin
            t = 47'(crystal) << K3;
            if (in_item.acc >= t)
            begin
                item_next.acc   = in_item.acc - t;
                item_next.q[K3] = 1'b1;
            end
        end
        else
        begin
            numv  = (crystal == '0) ? '0 : in_item.q;
            multv = (crystal == '0) ? '0 : in_item.mult;
            x     = {numv, 7'b0};
            q0    = {1'b0, x[26:20]};
            r21   = {1'b0, x[19:0]} + 21'(x[26:20]);
            if (r21 >= 21'(FRAC_DEN))
            begin
                q0  = q0 + 8'd1;
                r21 = r21 - 21'(FRAC_DEN);
            end
            item_next.p2     = r21[19:0];
            item_next.p1_pll = 18'({multv, 7'b0}) + 18'(q0) - P1_OFFSET;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
endmodule

FILE: sv/cfpu_pipe.sv
// divider chain from request to packed plan parameters
module cfpu_pipe (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [1:0]      channel,
    input  logic [27:0]     target_hz,
    input  logic            pll_select,
    input  logic [2:0]      rdiv_exponent,
    input  logic [25:0]     crystal,
    output logic            fin_valid,
    output cfpu_pkg::plan_t fin_plan
);
    import cfpu_pkg::*;

    logic   v [0:NSTAGE-1];
    item_t  it [0:NSTAGE-1];
    logic   valid0_reg;
    item_t  item0_reg;
    item_t  item0_next;

    always_comb
    begin
        item0_next        = '0;
        item0_next.chan   = channel;
        item0_next.pll_b  = pll_select;
        item0_next.expo   = rdiv_exponent;
        item0_next.off    = (target_hz == '0);
        item0_next.scaled = 35'(target_hz) << rdiv_exponent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid0_reg <= 1'b0;
        else if (en)
            valid0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item0_reg <= item0_next;
    end

    assign v[0]  = valid0_reg;
    assign it[0] = item0_reg;

    for (genvar i = 1; i < NSTAGE; i++)
    begin : g_stage
        cfpu_stage #(.IDX(i)) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_valid (v[i-1]),
            .in_item  (it[i-1]),
            .crystal  (crystal),
            .out_valid(v[i]),
            .out_item (it[i])
        );
    end

    assign fin_valid       = v[NSTAGE-1];
    assign fin_plan.chan   = it[NSTAGE-1].chan;
    assign fin_plan.pll_b  = it[NSTAGE-1].pll_b;
    assign fin_plan.expo   = it[NSTAGE-1].expo;
    assign fin_plan.off    = it[NSTAGE-1].off;
    assign fin_plan.div    = it[NSTAGE-1].div;
    assign fin_plan.p1_pll = it[NSTAGE-1].p1_pll;
    assign fin_plan.p2     = it[NSTAGE-1].p2;
endmodule

FILE: sv/cfpu_emit.sv
// sequencer that turns one plan into its register write beats
module cfpu_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fin_valid,
    input  cfpu_pkg::plan_t      fin_plan,
    output logic                 take_ready,
    output cfpu_pkg::emit_stat_t stat,
    cfpu_wr_if.source            wr
);
    import cfpu_pkg::*;

    logic        busy_reg;
    logic [4:0]  cnt_reg;
    plan_t       plan_reg;
    logic        last_beat;
    logic        take;
    logic [15:0] word;

    assign last_beat  = plan_reg.off || (cnt_reg == BEAT_CLK);
    assign take_ready = !busy_reg || (wr.ready && last_beat);
    assign take       = fin_valid && take_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (take)
        begin
            busy_reg <= (fin_plan.chan != CHAN_NONE);
            cnt_reg  <= '0;
        end
        else if (busy_reg && wr.ready)
        begin
            if (last_beat)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            plan_reg <= fin_plan;
    end

    assign word        = beat_word(plan_reg, cnt_reg);
    assign wr.valid    = busy_reg;
    assign wr.reg_addr = word[15:8];
    assign wr.reg_byte = word[7:0];
    assign wr.last     = last_beat;
    assign stat.busy   = busy_reg;
    assign stat.cnt    = cnt_reg;
endmodule

FILE: tb/sv/tb_clock_synth_frequency_plan_unit.sv
// self-checking testbench for the clock synthesizer frequency plan unit
`timescale 1ns / 1ps

module tb_clock_synth_frequency_plan_unit;
    import cfpu_pkg::*;

    typedef struct packed {
        logic [7:0] addr;
        logic [7:0] data;
        logic       last;
    } write_t;

    typedef enum logic [1:0] {ROW_PREDICT, ROW_OFF, ROW_NONE} row_kind_t;

    typedef struct packed {
        logic [1:0]  chan;
        logic [27:0] hz;
        logic        pll_b;
        logic [2:0]  expo;
        row_kind_t   kind;
    } row_t;

    localparam int DRAIN_CYCLES = 120;
    localparam int STALL_LIMIT  = 4000;
    localparam int NUM_DIRECTED = 18;
    localparam int RAND_PER_PHASE = 74;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    cfpu_req_if req ();
    cfpu_wr_if  wr ();

    clock_synth_frequency_plan_unit DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req.sink),
        .wr      (wr.source)
    );

    write_t      pending_writes[$];
    logic [25:0] crystal;
    int          snd_pct;
    int          rcv_pct;
    int          mismatches;
    int          writes_seen;
    int          requests_sent;
    int          quiet_cycles;
    row_t        directed_rows[NUM_DIRECTED];

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic void push_write(logic [7:0] addr, logic [7:0] data);
        write_t w;
        w.addr = addr;
        w.data = data;
        w.last = 1'b0;
        pending_writes.push_back(w);
    endfunction

    function automatic void push_divider_block(logic [7:0] base, logic [31:0] p1,
                                               logic [31:0] p2, logic [31:0] p3,
                                               logic [7:0] extra);
        push_write(base + 8'd0, 8'(p3 >> 8));
        push_write(base + 8'd1, 8'(p3));
        push_write(base + 8'd2, 8'(((p1 >> 16) & 32'h3) | 32'(extra)));
        push_write(base + 8'd3, 8'(p1 >> 8));
        push_write(base + 8'd4, 8'(p1));
        push_write(base + 8'd5,
                   8'(((p3 & 32'h000F0000) >> 12) | ((p2 & 32'h000F0000) >> 16)));
        push_write(base + 8'd6, 8'(p2 >> 8));
        push_write(base + 8'd7, 8'(p2));
    endfunction

    function automatic void plan_writes(logic [1:0] chan, logic [27:0] hz, logic pll_b,
                                        logic [2:0] expo);
        logic [63:0] scaled;
        logic [63:0] dv;
        logic [63:0] vco;
        logic [63:0] num;
        logic [31:0] mult;
        logic [31:0] p1;
        logic [31:0] p2;
        write_t      w;
        if (chan == CHAN_NONE)
            return;
        if (hz == 0)
        begin
            push_write(REG_CLK0 + 8'(chan), CLK_OFF);
        end
        else
        begin
            scaled = 64'(hz) << expo;
            dv = 64'(CEIL_HZ) / scaled;
            if (dv < 64'(DIV_MIN))
                dv = 64'(DIV_MIN);
            if (dv > 64'(DIV_MAX))
                dv = 64'(DIV_MAX);
            if (dv[0])
                dv = dv - 64'd1;
            vco = dv * scaled;
            if (crystal == 0)
            begin
                mult = '0;
                num = '0;
            end
            else
            begin
                mult = 32'((vco / 64'(crystal)) & 64'hFF);
                num = ((vco % 64'(crystal)) * 64'(FRAC_DEN)) / 64'(crystal);
            end
            p1 = 32'd128 * mult + 32'((num * 128) / 64'(FRAC_DEN)) - 32'd512;
            p2 = 32'((num * 128) % 64'(FRAC_DEN));
            push_divider_block(pll_b ? REG_PLL_B : REG_PLL_A, p1, p2, 32'(FRAC_DEN), 8'h00);
            p1 = 32'd128 * 32'(dv) - 32'd512;
            push_divider_block(REG_MS0 + 8'(chan) * 8'd8, p1, 32'd0, 32'd1,
                               {1'b0, expo, 4'b0});
            push_write(REG_PLL_RST, pll_b ? RST_PLL_B : RST_PLL_A);
            push_write(REG_CLK0 + 8'(chan), CLK_ON | (pll_b ? SRC_PLL_B : 8'h00));
        end
        w = pending_writes.pop_back();
        w.last = 1'b1;
        pending_writes.push_back(w);
    endfunction

    task automatic send_request(row_t r);
        write_t w;
        while ($urandom_range(99) < snd_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid         <= 1'b1;
        req.channel       <= r.chan;
        req.target_hz     <= r.hz;
        req.pll_select    <= r.pll_b;
        req.rdiv_exponent <= r.expo;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        case (r.kind)
            ROW_OFF:
            begin
                w.addr = REG_CLK0 + 8'(r.chan);
                w.data = CLK_OFF;
                w.last = 1'b1;
                pending_writes.push_back(w);
            end
            ROW_NONE: ;
            default: plan_writes(r.chan, r.hz, r.pll_b, r.expo);
        endcase
        requests_sent++;
        @(negedge clk);
    endtask

    task automatic drain_and_settle();
        req.valid <= 1'b0;
        while (pending_writes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_crystal(logic [25:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_CRYSTAL;
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        crystal = value;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic row_t random_request();
        row_t r;
        int   pick;
        r.kind  = ROW_PREDICT;
        r.pll_b = 1'($urandom_range(1));
        r.expo  = 3'($urandom_range(7));
        r.chan  = ($urandom_range(19) == 0) ? CHAN_NONE : 2'($urandom_range(2));
        pick = $urandom_range(19);
        if (pick == 0)
            r.hz = 28'd0;
        else if (pick < 4)
            r.hz = 28'($urandom_range(100000));
        else if (pick < 6)
            r.hz = 28'($urandom());
        else
            r.hz = 28'($urandom_range(200000000));
        return r;
    endfunction

    always @(negedge clk)
        wr.ready <= ($urandom_range(99) >= rcv_pct);

    always @(posedge clk)
    begin
        write_t got;
        write_t want;
        got.addr = wr.reg_addr;
        got.data = wr.reg_byte;
        got.last = wr.last;
        if ((wr.valid && wr.ready) || (req.valid && req.ready))
            quiet_cycles = 0;
        else if (rst_n)
            quiet_cycles++;
        if (rst_n && wr.valid && wr.ready)
        begin
            writes_seen++;
            if (pending_writes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat addr %0d data %02h last %0b",
                             got.addr, got.data, got.last);
            end
            else
            begin
                want = pending_writes.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"beat %0d: expected addr %0d data %02h last %0b, ",
                                  "got addr %0d data %02h last %0b"},
                                 writes_seen, want.addr, want.data, want.last,
                                 got.addr, got.data, got.last);
                end
            end
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout with %0d beats outstanding", pending_writes.size());
            $display("clock_synth_frequency_plan_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        logic [25:0] crystal_plan[6];
        directed_rows[0]  = '{2'd0, 28'd0, 1'b0, 3'd0, ROW_OFF};
        directed_rows[1]  = '{2'd1, 28'd0, 1'b1, 3'd7, ROW_OFF};
        directed_rows[2]  = '{2'd2, 28'd0, 1'b0, 3'd3, ROW_OFF};
        directed_rows[3]  = '{2'd3, 28'd100000000, 1'b1, 3'd2, ROW_NONE};
        directed_rows[4]  = '{2'd3, 28'd0, 1'b0, 3'd0, ROW_NONE};
        directed_rows[5]  = '{2'd0, 28'd1, 1'b0, 3'd0, ROW_PREDICT};
        directed_rows[6]  = '{2'd2, 28'd200000000, 1'b1, 3'd7, ROW_PREDICT};
        directed_rows[7]  = '{2'd1, 28'hFFFFFFF, 1'b1, 3'd7, ROW_PREDICT};
        directed_rows[8]  = '{2'd0, 28'd10000000, 1'b0, 3'd0, ROW_PREDICT};
        directed_rows[9]  = '{2'd1, 28'd1000000, 1'b1, 3'd3, ROW_PREDICT};
        directed_rows[10] = '{2'd2, 28'd123456789, 1'b0, 3'd5, ROW_PREDICT};
        directed_rows[11] = '{2'd1, 28'd225000000, 1'b0, 3'd0, ROW_PREDICT};
        directed_rows[12] = '{2'd0, 28'd439453, 1'b1, 3'd0, ROW_PREDICT};
        directed_rows[13] = '{2'd2, 28'd300000, 1'b0, 3'd0, ROW_PREDICT};
        directed_rows[14] = '{2'd0, 28'd7, 1'b1, 3'd7, ROW_PREDICT};
        directed_rows[15] = '{2'd1, 28'd2, 1'b0, 3'd1, ROW_PREDICT};
        directed_rows[16] = '{2'd2, 28'd150000000, 1'b1, 3'd1, ROW_PREDICT};
        directed_rows[17] = '{2'd0, 28'h5555555, 1'b0, 3'd6, ROW_PREDICT};
        crystal_plan[0] = CRYSTAL_RST;
        crystal_plan[1] = 26'd10000000;
        crystal_plan[2] = 26'd40000000;
        crystal_plan[3] = 26'd0;
        crystal_plan[4] = 26'h3FFFFFF;
        crystal_plan[5] = 26'($urandom_range(40000000, 10000000));

        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        req.valid         = 1'b0;
        req.channel       = '0;
        req.target_hz     = '0;
        req.pll_select    = 1'b0;
        req.rdiv_exponent = '0;
        wr.ready          = 1'b0;
        crystal           = CRYSTAL_RST;
        snd_pct           = 8;
        rcv_pct           = 47;
        mismatches        = 0;
        writes_seen       = 0;
        requests_sent     = 0;
        quiet_cycles      = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < NUM_DIRECTED; i++)
            send_request(directed_rows[i]);

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph == 2)
            begin
                snd_pct = 47;
                rcv_pct = 8;
            end
            else if (ph == 4)
            begin
                snd_pct = 0;
                rcv_pct = 0;
            end
            drain_and_settle();
            write_crystal(crystal_plan[ph]);
            for (int i = 0; i < RAND_PER_PHASE; i++)
                send_request(random_request());
        end

        drain_and_settle();
        $display("%0d requests and %0d register write beats over 6 crystal settings",
                 requests_sent, writes_seen);
        if (mismatches == 0 && pending_writes.size() == 0)
            $display("clock_synth_frequency_plan_unit verification clean");
        else
            $display("clock_synth_frequency_plan_unit verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/cfpu_pkg.sv
sv/cfpu_if.sv
sv/cfpu_stage.sv
sv/cfpu_pipe.sv
sv/cfpu_emit.sv
sv/clock_synth_frequency_plan_unit.sv
tb/sv/tb_clock_synth_frequency_plan_unit.sv
